/* rtl/adc_scan_average_fifo_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ADC scan core
// Same-cycle and next-cycle property shorthands on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ADC_SCAN_AVERAGE_FIFO_CORE_DEFINES_SVH
`define ADC_SCAN_AVERAGE_FIFO_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASAF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/asaf_pkg.sv */
// ----------------------------------------------------------------------------
// ADC scan average FIFO package
// Sizes, codes and derived arithmetic constants shared by the core.
// ----------------------------------------------------------------------------
package asaf_pkg;

  localparam int FIFO_DEPTH    = 1024;
  localparam int AVERAGE_COUNT = 1;
  localparam int CHANNEL_COUNT = 8;

  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CH_W      = 3;
  localparam int CH_IDX_W  = $clog2(CHANNEL_COUNT);
  localparam int MASK_W    = 8;
  localparam logic [MASK_W-1:0] CH_MASK = MASK_W'((1 << CHANNEL_COUNT) - 1);

  localparam int CODE_W    = 24;
  localparam int VALUE_W   = 24;
  localparam int SLOT_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd39059;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam logic [7:0] MUX_FLAG = 8'h08;

  // Sum of AVERAGE_COUNT codes, and its sample counter
  localparam int AVG_LOG = $clog2(AVERAGE_COUNT);
  localparam int SUM_W   = CODE_W + AVG_LOG;
  localparam int CNT_W   = $clog2(AVERAGE_COUNT + 1);

  // Floor division by AVERAGE_COUNT: bias the sum to a nonnegative value,
  // multiply by a rounded-up reciprocal and shift.
  localparam int U_W     = CODE_W + 2 * AVG_LOG;
  localparam int MUL_W   = U_W + 2;
  localparam int DIV_SH  = U_W + AVG_LOG;
  localparam int DPROD_W = U_W + MUL_W;
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'((64'd1 << DIV_SH) / AVERAGE_COUNT + 1);
  localparam logic [U_W-1:0] DIV_BIAS =
    U_W'(AVERAGE_COUNT * (64'd1 << (SUM_W - 1)));

  // Signed average times unsigned gain
  localparam int SCALE_W = SUM_W + GAIN_W + 1;

  // FIFO entry: channel above value
  localparam int ENTRY_W = CH_W + VALUE_W;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_MASK = 1'd0,
    CFG_SCALE_GAIN   = 1'd1
  } cfg_reg_e;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

/* rtl/asaf_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module asaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/adc_scan_average_fifo_core.sv */
// ----------------------------------------------------------------------------
// ADC scan average FIFO core
// Round-robin channel scan with per-channel averaging, Q16 microvolt scaling
// and a ring FIFO of results read by pop and peek requests.
// ----------------------------------------------------------------------------
//
//  port group  dir  payload
//  s_axis      in   tuser: action; tdata: raw_code, slot
//  m_axis      out  tuser: ok; tdata: value, channel, next_channel, mux_word
//  cfg         in   cfg_idx_i selects channel_mask or scale_gain, cfg_wdata_i
//
//  One request per cycle while the output is not stalled; results pass s1_q to s4_q.
//  Stages: scan and sum update, reciprocal divide multiply, gain multiply,
//  FIFO memory access (one write or one read per cycle), output register.
//  Reset clears pointers, sums, scan position, valid bits and configuration;
//  the FIFO memory is not cleared and no request is blocked after reset.
//  A stalled output holds; earlier stages keep filling until all four hold.
// ----------------------------------------------------------------------------
`include "adc_scan_average_fifo_core_defines.svh"

module adc_scan_average_fifo_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [39:0]                   s_axis_tdata,  // raw_code[23:0], slot[39:24]
  input  logic [1:0]                    s_axis_tuser,  // action[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,  // value[23:0], channel[26:24],
                                                       // next_channel[29:27],
                                                       // mux_word[37:30], zero[39:38]
  output logic                          m_axis_tuser,  // ok[0]
  input  logic                          cfg_we_i,
  input  logic [asaf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [asaf_pkg::CFG_W-1:0]    cfg_wdata_i
);

  typedef struct packed {
    asaf_pkg::action_e                 act;
    logic [asaf_pkg::SLOT_W-1:0]       slot;
    logic [asaf_pkg::CH_W-1:0]         ch;
    logic [asaf_pkg::CH_W-1:0]         nxt;
    logic                              done;
    logic signed [asaf_pkg::SUM_W-1:0] sum;
  } st1_t;

  typedef struct packed {
    asaf_pkg::action_e                 act;
    logic [asaf_pkg::SLOT_W-1:0]       slot;
    logic [asaf_pkg::CH_W-1:0]         ch;
    logic [asaf_pkg::CH_W-1:0]         nxt;
    logic                              done;
    logic [asaf_pkg::DPROD_W-1:0]      prod;
  } st2_t;

  typedef struct packed {
    asaf_pkg::action_e                   act;
    logic [asaf_pkg::SLOT_W-1:0]         slot;
    logic [asaf_pkg::CH_W-1:0]           ch;
    logic [asaf_pkg::CH_W-1:0]           nxt;
    logic                                done;
    logic signed [asaf_pkg::SCALE_W-1:0] scaled;
  } st3_t;

  typedef struct packed {
    logic                         ok;
    logic                         from_ram;
    logic [asaf_pkg::VALUE_W-1:0] val;
    logic [asaf_pkg::CH_W-1:0]    chan;
    logic [asaf_pkg::CH_W-1:0]    nxt;
  } st4_t;

  // Configuration
  logic [asaf_pkg::MASK_W-1:0] mask_q;
  logic [asaf_pkg::GAIN_W-1:0] gain_q;

  // Scan and accumulation state
  logic [asaf_pkg::CH_W-1:0]         cur_q, cur_d;
  logic signed [asaf_pkg::SUM_W-1:0] sum_q [asaf_pkg::CHANNEL_COUNT];
  logic [asaf_pkg::CNT_W-1:0]        cnt_q [asaf_pkg::CHANNEL_COUNT];

  // FIFO pointers
  logic [asaf_pkg::PTR_W-1:0] head_q, tail_q;
  logic [asaf_pkg::PTR_W-1:0] head_nxt;

  // Pipeline
  logic v1_q, v2_q, v3_q, v4_q;
  st1_t s1_q, s1_d;
  st2_t s2_q, s2_d;
  st3_t s3_q, s3_d;
  st4_t s4_q, s4_d;
  logic rdy1, rdy2, rdy3, rdy4;
  logic adv3;
  logic in_fire;

  // Stage 0 signals
  asaf_pkg::action_e                 in_act;
  logic [asaf_pkg::CODE_W-1:0]       in_raw;
  logic [asaf_pkg::SLOT_W-1:0]       in_slot;
  logic [asaf_pkg::CH_IDX_W-1:0]     ch_idx;
  logic signed [asaf_pkg::SUM_W-1:0] sum_new;
  logic [asaf_pkg::CNT_W-1:0]        cnt_new;
  logic                              avg_done;
  logic                              is_sample;

  // Stage 1 and 2 signals
  logic [asaf_pkg::U_W-1:0]          div_in;
  logic signed [asaf_pkg::SUM_W-1:0] avg;

  // Stage 3 signals
  logic signed [asaf_pkg::SCALE_W-1:0] scaled_adj;
  logic [asaf_pkg::VALUE_W-1:0]        uv;
  logic                                push, pop, rd_req;
  logic [asaf_pkg::PTR_W-1:0]          rd_addr;

  // Memory port
  logic                         ram_we, ram_re;
  logic [asaf_pkg::ENTRY_W-1:0] ram_rdata;

  // Output side
  logic [asaf_pkg::VALUE_W-1:0] out_val;
  logic [asaf_pkg::CH_W-1:0]    out_chan;

  // --------------------------------------------------------------------------
  // Handshake chain
  // --------------------------------------------------------------------------
  assign rdy4          = !v4_q || m_axis_tready;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign adv3          = v3_q && rdy4;
  assign s_axis_tready = rdy1;
  assign in_fire       = s_axis_tvalid && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      gain_q <= asaf_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      case (asaf_pkg::cfg_reg_e'(cfg_idx_i))
        asaf_pkg::CFG_CHANNEL_MASK: mask_q <= cfg_wdata_i[asaf_pkg::MASK_W-1:0];
        asaf_pkg::CFG_SCALE_GAIN:   gain_q <= cfg_wdata_i[asaf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: accumulate the sample and advance the scan
  // --------------------------------------------------------------------------
  assign in_act    = asaf_pkg::action_e'(s_axis_tuser);
  assign in_raw    = s_axis_tdata[asaf_pkg::CODE_W-1:0];
  assign in_slot   = s_axis_tdata[asaf_pkg::CODE_W +: asaf_pkg::SLOT_W];
  assign ch_idx    = cur_q[asaf_pkg::CH_IDX_W-1:0];
  assign is_sample = in_fire && (in_act == asaf_pkg::ACT_SAMPLE);
  assign sum_new   = sum_q[ch_idx] + asaf_pkg::SUM_W'($signed(in_raw));
  assign cnt_new   = cnt_q[ch_idx] + asaf_pkg::CNT_W'(1);
  assign avg_done  = (cnt_new == asaf_pkg::CNT_W'(asaf_pkg::AVERAGE_COUNT));

  // Search from the channel after the current one; the current one comes last.
  always_comb begin
    logic [3:0] cand;
    cur_d = cur_q;
    for (int i = asaf_pkg::CHANNEL_COUNT; i >= 1; i--) begin
      cand = {1'b0, cur_q} + 4'(i);
      if (cand >= 4'(asaf_pkg::CHANNEL_COUNT)) begin
        cand = cand - 4'(asaf_pkg::CHANNEL_COUNT);
      end
      if (mask_q[cand[asaf_pkg::CH_W-1:0]]) begin
        cur_d = cand[asaf_pkg::CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      for (int i = 0; i < asaf_pkg::CHANNEL_COUNT; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (is_sample) begin
      cur_q <= cur_d;
      if (avg_done) begin
        sum_q[ch_idx] <= '0;
        cnt_q[ch_idx] <= '0;
      end else begin
        sum_q[ch_idx] <= sum_new;
        cnt_q[ch_idx] <= cnt_new;
      end
    end
  end

  always_comb begin
    s1_d.act  = in_act;
    s1_d.slot = in_slot;
    s1_d.ch   = cur_q;
    s1_d.nxt  = (in_act == asaf_pkg::ACT_SAMPLE) ? cur_d : cur_q;
    s1_d.done = avg_done;
    s1_d.sum  = sum_new;
  end

  // --------------------------------------------------------------------------
  // Stage 1: floor divide by the sample count through a reciprocal multiply
  // --------------------------------------------------------------------------
  assign div_in = asaf_pkg::U_W'($signed(s1_q.sum)) + asaf_pkg::DIV_BIAS;

  always_comb begin
    s2_d.act  = s1_q.act;
    s2_d.slot = s1_q.slot;
    s2_d.ch   = s1_q.ch;
    s2_d.nxt  = s1_q.nxt;
    s2_d.done = s1_q.done;
    s2_d.prod = {{asaf_pkg::MUL_W{1'b0}}, div_in}
              * {{asaf_pkg::U_W{1'b0}}, asaf_pkg::DIV_MUL};
  end

  // --------------------------------------------------------------------------
  // Stage 2: drop the bias and scale by the gain
  // --------------------------------------------------------------------------
  // Quotient lies in [0, 2*bias): removing the bias flips the top bit.
  assign avg = {~s2_q.prod[asaf_pkg::DIV_SH + asaf_pkg::SUM_W - 1],
                s2_q.prod[asaf_pkg::DIV_SH +: asaf_pkg::SUM_W - 1]};

  always_comb begin
    s3_d.act    = s2_q.act;
    s3_d.slot   = s2_q.slot;
    s3_d.ch     = s2_q.ch;
    s3_d.nxt    = s2_q.nxt;
    s3_d.done   = s2_q.done;
    s3_d.scaled = asaf_pkg::SCALE_W'(avg)
                * asaf_pkg::SCALE_W'($signed({1'b0, gain_q}));
  end

  // --------------------------------------------------------------------------
  // Stage 3: truncate toward zero, then FIFO push, pop or peek
  // --------------------------------------------------------------------------
  assign scaled_adj = s3_q.scaled
                    + (s3_q.scaled[asaf_pkg::SCALE_W-1]
                       ? asaf_pkg::SCALE_W'((1 << asaf_pkg::GAIN_FRAC) - 1)
                       : asaf_pkg::SCALE_W'(0));
  assign uv       = scaled_adj[asaf_pkg::GAIN_FRAC +: asaf_pkg::VALUE_W];
  assign head_nxt = asaf_pkg::ptr_next(head_q);

  always_comb begin
    push    = 1'b0;
    pop     = 1'b0;
    rd_req  = 1'b0;
    rd_addr = tail_q;
    s4_d.ok       = 1'b0;
    s4_d.from_ram = 1'b0;
    s4_d.val      = '0;
    s4_d.chan     = '0;
    s4_d.nxt      = s3_q.nxt;
    case (s3_q.act)
      asaf_pkg::ACT_SAMPLE: begin
        s4_d.chan = s3_q.ch;
        // Drop zero results and pushes into a full FIFO.
        if (s3_q.done && (uv != '0) && (head_nxt != tail_q)) begin
          push     = 1'b1;
          s4_d.ok  = 1'b1;
          s4_d.val = uv;
        end
      end
      asaf_pkg::ACT_POP: begin
        if (head_q != tail_q) begin
          pop           = 1'b1;
          rd_req        = 1'b1;
          s4_d.ok       = 1'b1;
          s4_d.from_ram = 1'b1;
        end
      end
      asaf_pkg::ACT_PEEK: begin
        if ({1'b0, s3_q.slot} < (asaf_pkg::SLOT_W + 1)'(asaf_pkg::FIFO_DEPTH)) begin
          rd_req        = 1'b1;
          rd_addr       = s3_q.slot[asaf_pkg::PTR_W-1:0];
          s4_d.ok       = 1'b1;
          s4_d.from_ram = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign ram_we = adv3 && push;
  assign ram_re = adv3 && rd_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (adv3) begin
      if (push) begin
        head_q <= head_nxt;
      end
      if (pop) begin
        tail_q <= asaf_pkg::ptr_next(tail_q);
      end
    end
  end

  asaf_ram #(
    .WIDTH(asaf_pkg::ENTRY_W),
    .DEPTH(asaf_pkg::FIFO_DEPTH)
  ) u_fifo_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(head_q),
    .wdata_i({s3_q.ch, uv}),
    .re_i   (ram_re),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (v1_q && rdy2) begin
      s2_q <= s2_d;
    end
    if (v2_q && rdy3) begin
      s3_q <= s3_d;
    end
    if (adv3) begin
      s4_q <= s4_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output
  // --------------------------------------------------------------------------
  assign out_val  = s4_q.from_ram ? ram_rdata[asaf_pkg::VALUE_W-1:0] : s4_q.val;
  assign out_chan = s4_q.from_ram ? ram_rdata[asaf_pkg::VALUE_W +: asaf_pkg::CH_W]
                                  : s4_q.chan;

  assign m_axis_tvalid = v4_q;
  assign m_axis_tuser  = s4_q.ok;
  assign m_axis_tdata  = {2'b00,
                          (asaf_pkg::MUX_FLAG | {1'b0, s4_q.nxt, 4'b0000}),
                          s4_q.nxt,
                          out_chan,
                          out_val};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASAF_ASSERT_SAME(a_ram_single_access, ram_we, !ram_re, "FIFO memory written and read together")
  `ASAF_ASSERT_NEXT(a_rdata_held, m_axis_tvalid && !m_axis_tready && s4_q.from_ram, $stable(ram_rdata), "read data lost while output stalled")
  `ASAF_ASSERT_NEXT(a_head_moves_on_push, !ram_we, $stable(head_q), "head moved without a push")
  `ASAF_ASSERT_NEXT(a_scan_lands_enabled, is_sample && !cfg_we_i && ((mask_q & asaf_pkg::CH_MASK) != '0), mask_q[cur_q], "scan moved to a disabled channel")

endmodule
